@@ rtl/core/tsjs_pkg.sv @@
// ----------------------------------------------------------------------------
// tsjs_pkg
// Shared types and constants for the two-slot job scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsjs_pkg;

	localparam int GEN_BITS    = 8;
	localparam int TIMER_BITS  = 16;
	localparam int STREAK_BITS = 4;
	localparam int NUM_SLOTS   = 2;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 4;

	localparam logic [STREAK_BITS-1:0] STREAK_RESET = STREAK_BITS'(4);

	// Request codes; codes 5 to 7 only trigger a dispatch attempt.
	typedef enum logic [2:0] {
		REQ_REQUEST = 3'd0,
		REQ_CANCEL  = 3'd1,
		REQ_TICK    = 3'd2,
		REQ_DONE    = 3'd3,
		REQ_STOP    = 3'd4
	} req_type_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_BOUND_MASK  = 1'd0,
		CFG_STARV_LIMIT = 1'd1
	} cfg_index_t;

	typedef logic [GEN_BITS-1:0]   gen_t;
	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef struct packed {
		logic accepted;
		logic grant_valid;
		logic grant_slot;
		gen_t grant_generation;
		logic halted;
	} result_t;

endpackage

@@ rtl/core/tsjs_if.sv @@
// ----------------------------------------------------------------------------
// tsjs_if
// Request and result channels of the two-slot job scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsjs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic        slot;
	logic [15:0] retry_ms;
	logic        no_retry;

	modport source (output valid, req_type, slot, retry_ms, no_retry, input ready);
	modport sink   (input valid, req_type, slot, retry_ms, no_retry, output ready);
endinterface

interface tsjs_rsp_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic       grant_valid;
	logic       grant_slot;
	logic [7:0] grant_generation;
	logic       halted;

	modport source (output valid, accepted, grant_valid, grant_slot, grant_generation, halted,
		input ready);
	modport sink   (input valid, accepted, grant_valid, grant_slot, grant_generation, halted,
		output ready);
endinterface

@@ rtl/core/two_slot_job_scheduler.sv @@
// ----------------------------------------------------------------------------
// two_slot_job_scheduler
// A request is registered in the input stage at acceptance; the scheduler state
// updates in the single decide stage, and the result is presented from the
// result register. One request per cycle while the result channel is not stalled.
// Reset (arst_n low) clears all slot state, the halt flag and the bound mask,
// and sets the starvation limit to 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_slot_job_scheduler
	import tsjs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	tsjs_req_if.sink                 req,
	tsjs_rsp_if.source               rsp
);

	// configuration
	logic [NUM_SLOTS-1:0]   bound_mask_q;
	logic [STREAK_BITS-1:0] starv_limit_q;

	// scheduler state
	logic [NUM_SLOTS-1:0]   pending_q;
	gen_t                   slot_gen_q   [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]   retry_armed_q;
	timer_t                 retry_left_q [NUM_SLOTS];
	gen_t                   retry_gen_q  [NUM_SLOTS];
	logic [STREAK_BITS-1:0] streak_q;
	logic                   busy_q;
	logic                   busy_slot_q;
	gen_t                   busy_gen_q;
	logic                   halted_q;

	// input stage
	logic        valid_s1;
	logic [2:0]  req_type_s1;
	logic        slot_s1;
	timer_t      retry_ms_s1;
	logic        no_retry_s1;

	// result stage
	logic    valid_s2;
	result_t result_s2;

	logic fire_s1;
	logic adv_s2;

	// next state
	logic [NUM_SLOTS-1:0]   pending_d;
	gen_t                   slot_gen_d   [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]   retry_armed_d;
	timer_t                 retry_left_d [NUM_SLOTS];
	gen_t                   retry_gen_d  [NUM_SLOTS];
	logic [STREAK_BITS-1:0] streak_d;
	logic                   busy_d;
	logic                   busy_slot_d;
	gen_t                   busy_gen_d;
	logic                   halted_d;
	result_t                result_d;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign fire_s1   = valid_s1 && adv_s2;
	assign req.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_mask_q  <= '0;
			starv_limit_q <= STREAK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOUND_MASK:  bound_mask_q  <= cfg_data[NUM_SLOTS-1:0];
				CFG_STARV_LIMIT: starv_limit_q <= cfg_data[STREAK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			slot_s1     <= req.slot;
			retry_ms_s1 <= TIMER_BITS'(req.retry_ms);
			no_retry_s1 <= req.no_retry;
		end
		if (fire_s1) begin
			result_s2 <= result_d;
		end
	end

	// Decide: apply the request, then try one dispatch.
	always_comb begin
		logic       low_first;
		logic       found;
		logic       idx;
		logic       ready_slot;
		logic [STREAK_BITS:0] streak_inc;

		pending_d     = pending_q;
		slot_gen_d    = slot_gen_q;
		retry_armed_d = retry_armed_q;
		retry_left_d  = retry_left_q;
		retry_gen_d   = retry_gen_q;
		streak_d      = streak_q;
		busy_d        = busy_q;
		busy_slot_d   = busy_slot_q;
		busy_gen_d    = busy_gen_q;
		halted_d      = halted_q;
		result_d      = '0;
		result_d.accepted = 1'b1;
		idx           = 1'b0;
		ready_slot    = 1'b0;

		case (req_type_s1)
			REQ_REQUEST: begin
				if (halted_q) begin
					result_d.accepted = 1'b0;
				end else begin
					pending_d[slot_s1] = 1'b1;
				end
			end
			REQ_CANCEL: begin
				slot_gen_d[slot_s1] = slot_gen_q[slot_s1] + 1'b1;
				pending_d[slot_s1]  = 1'b0;
			end
			REQ_TICK: begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (retry_armed_q[s] && retry_left_q[s] != '0) begin
						retry_left_d[s] = retry_left_q[s] - 1'b1;
					end
				end
			end
			REQ_DONE: begin
				if (busy_q) begin
					if (!no_retry_s1 && !halted_q && slot_gen_q[busy_slot_q] == busy_gen_q) begin
						retry_armed_d[busy_slot_q] = 1'b1;
						retry_left_d[busy_slot_q]  = retry_ms_s1;
						retry_gen_d[busy_slot_q]   = busy_gen_q;
					end
					busy_d = 1'b0;
				end
			end
			REQ_STOP: begin
				halted_d      = 1'b1;
				pending_d     = '0;
				retry_armed_d = '0;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					retry_left_d[s] = '0;
				end
			end
			default: ;
		endcase

		low_first  = streak_q >= starv_limit_q;
		found      = 1'b0;
		streak_inc = {1'b0, streak_q} + 1'b1;
		if (!halted_d && !busy_d) begin
			for (int pos = 0; pos < NUM_SLOTS; pos++) begin
				idx = low_first ^ pos[0];
				ready_slot = pending_d[idx] ||
					(retry_armed_d[idx] && retry_left_d[idx] == '0 &&
					 retry_gen_d[idx] == slot_gen_d[idx]);
				if (!found && ready_slot) begin
					// consume readiness; unbound slots lose it
					pending_d[idx]     = 1'b0;
					retry_armed_d[idx] = 1'b0;
					retry_left_d[idx]  = '0;
					if (bound_mask_q[idx]) begin
						found       = 1'b1;
						busy_d      = 1'b1;
						busy_slot_d = idx;
						busy_gen_d  = slot_gen_d[idx];
						result_d.grant_valid      = 1'b1;
						result_d.grant_slot       = idx;
						result_d.grant_generation = slot_gen_d[idx];
						if (idx == 1'b0) begin
							streak_d = (streak_inc < {1'b0, starv_limit_q}) ?
								streak_inc[STREAK_BITS-1:0] : starv_limit_q;
						end else begin
							streak_d = '0;
						end
					end
				end
			end
		end
		result_d.halted = halted_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			retry_armed_q <= '0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_gen_q[s]   <= '0;
				retry_left_q[s] <= '0;
				retry_gen_q[s]  <= '0;
			end
			streak_q    <= '0;
			busy_q      <= 1'b0;
			busy_slot_q <= 1'b0;
			busy_gen_q  <= '0;
			halted_q    <= 1'b0;
		end else if (fire_s1) begin
			pending_q     <= pending_d;
			retry_armed_q <= retry_armed_d;
			slot_gen_q    <= slot_gen_d;
			retry_left_q  <= retry_left_d;
			retry_gen_q   <= retry_gen_d;
			streak_q      <= streak_d;
			busy_q        <= busy_d;
			busy_slot_q   <= busy_slot_d;
			busy_gen_q    <= busy_gen_d;
			halted_q      <= halted_d;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.accepted         = result_s2.accepted;
	assign rsp.grant_valid      = result_s2.grant_valid;
	assign rsp.grant_slot       = result_s2.grant_slot;
	assign rsp.grant_generation = result_s2.grant_generation;
	assign rsp.halted           = result_s2.halted;

`ifndef SYNTHESIS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared after stop");

	a_no_grant_halted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.halted |-> !result_s2.grant_valid)
		else $error("grant issued while halted");

	a_grant_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && result_d.grant_valid |=> busy_q && busy_gen_q == result_s2.grant_generation)
		else $error("grant did not mark the job busy");

	a_refuse_only_halted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.accepted |-> result_s2.halted)
		else $error("request refused while running");

	a_no_grant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && busy_q && req_type_s1 != REQ_DONE |-> !result_d.grant_valid)
		else $error("grant issued while a job is busy");
`endif

endmodule

@@ tb/tb_two_slot_job_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_two_slot_job_scheduler
// Self-checking bench for the two-slot job scheduler. Requests go in through
// the request channel with random gaps. Each accepted request is run through
// a local prediction of the dispatcher, and the result it should produce is
// queued. A checker process pops the queue on every accepted result and
// compares all fields. Directed sequences cover unbound slots, unused codes,
// retries, cancels, the streak guard at its limits and stop. Random phases
// under several settings follow, then a generation wrap run and the stop
// sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_slot_job_scheduler;
	import tsjs_pkg::*;

	localparam int          STALL_LIMIT   = 2000;
	localparam int          SHOW_LIMIT    = 10;
	localparam int          PHASE_ITEMS   = 110;
	localparam int          WRAP_ITEMS    = 360;
	localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	tsjs_req_if req_ch ();
	tsjs_rsp_if rsp_ch ();

	two_slot_job_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Predicted scheduler state
	logic [1:0]           bound_mask;
	logic [STREAK_BITS-1:0] streak_limit;
	logic                 slot_pending [NUM_SLOTS];
	gen_t                 slot_gen     [NUM_SLOTS];
	logic                 retry_on     [NUM_SLOTS];
	timer_t               retry_count  [NUM_SLOTS];
	gen_t                 retry_tag    [NUM_SLOTS];
	logic [STREAK_BITS-1:0] hi_streak;
	logic                 job_running;
	logic                 running_slot;
	gen_t                 running_gen;
	logic                 stopped;

	result_t outcome_q [$];
	result_t got;
	result_t want;
	int      fail_count = 0;
	int      idle_cycles = 0;
	bit      quiet;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic result_t predict_outcome(input logic [2:0] code, input logic sl,
			input timer_t ms, input logic nr);
		result_t    r;
		logic       low_first;
		logic       rdy;
		int         idx;
		logic [4:0] next_streak;
		r = '0;
		r.accepted = 1'b1;
		case (code)
			REQ_REQUEST: begin
				if (stopped)
					r.accepted = 1'b0;
				else
					slot_pending[sl] = 1'b1;
			end
			REQ_CANCEL: begin
				slot_gen[sl] = slot_gen[sl] + 1'b1;
				slot_pending[sl] = 1'b0;
			end
			REQ_TICK: begin
				for (int s = 0; s < NUM_SLOTS; s++)
					if (retry_on[s] && retry_count[s] != '0)
						retry_count[s] = retry_count[s] - 1'b1;
			end
			REQ_DONE: begin
				if (job_running) begin
					// arm only if the slot was not cancelled while running
					if (!nr && !stopped && slot_gen[running_slot] == running_gen) begin
						retry_on[running_slot] = 1'b1;
						retry_count[running_slot] = ms;
						retry_tag[running_slot] = running_gen;
					end
					job_running = 1'b0;
				end
			end
			REQ_STOP: begin
				stopped = 1'b1;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					slot_pending[s] = 1'b0;
					retry_on[s] = 1'b0;
					retry_count[s] = '0;
				end
			end
			default: ;
		endcase

		if (!stopped && !job_running) begin
			low_first = (hi_streak >= streak_limit);
			for (int pos = 0; pos < NUM_SLOTS && !r.grant_valid; pos++) begin
				idx = low_first ? 1 - pos : pos;
				rdy = slot_pending[idx] ||
					(retry_on[idx] && retry_count[idx] == '0 && retry_tag[idx] == slot_gen[idx]);
				if (rdy) begin
					// readiness is consumed even when the slot is unbound
					slot_pending[idx] = 1'b0;
					retry_on[idx] = 1'b0;
					retry_count[idx] = '0;
					if (bound_mask[idx]) begin
						job_running = 1'b1;
						running_slot = idx[0];
						running_gen = slot_gen[idx];
						r.grant_valid = 1'b1;
						r.grant_slot = idx[0];
						r.grant_generation = slot_gen[idx];
						if (idx == 0) begin
							next_streak = {1'b0, hi_streak} + 5'd1;
							hi_streak = (next_streak < {1'b0, streak_limit}) ?
								next_streak[STREAK_BITS-1:0] : streak_limit;
						end else begin
							hi_streak = '0;
						end
					end
				end
			end
		end
		r.halted = stopped;
		return r;
	endfunction

	task automatic send_req(input logic [2:0] code, input logic sl, input timer_t ms,
			input logic nr);
		while (!quiet && $urandom_range(99) < 36) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= code;
		req_ch.slot     <= sl;
		req_ch.retry_ms <= ms;
		req_ch.no_retry <= nr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		outcome_q.push_back(predict_outcome(code, sl, ms, nr));
	endtask

	// Drain all outstanding results and let the pipeline empty.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] mask, input logic [STREAK_BITS-1:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BOUND_MASK;
		cfg_data  <= CFG_DATA_BITS'(mask);
		@(posedge clk);
		bound_mask = mask;
		cfg_index <= CFG_STARV_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		streak_limit = limit;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random();
		int     w;
		timer_t ms;
		w = $urandom_range(99);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: ms = timer_t'($urandom_range(3));
			5, 6, 7, 8:    ms = timer_t'($urandom_range(12, 4));
			default:       ms = timer_t'($urandom);
		endcase
		if (w < 32)
			send_req(REQ_REQUEST, 1'($urandom_range(1)), ms, 1'($urandom_range(1)));
		else if (w < 42)
			send_req(REQ_CANCEL, 1'($urandom_range(1)), ms, 1'($urandom_range(1)));
		else if (w < 64)
			send_req(REQ_TICK, 1'($urandom_range(1)), ms, 1'($urandom_range(1)));
		else if (w < 94)
			send_req(REQ_DONE, 1'($urandom_range(1)), ms, $urandom_range(3) == 0);
		else
			send_req(3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)),
				1'($urandom_range(1)), ms, 1'($urandom_range(1)));
	endtask

	task automatic test_unbound_and_unused();
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b1, '1, 1'b1);
		send_req(REQ_UNUSED_LO, 1'b0, '0, 1'b0);
		send_req(REQ_UNUSED_HI, 1'b1, '1, 1'b1);
		settle();
	endtask

	task automatic test_retry_and_cancel();
		write_cfg(2'd3, 4'd1);
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b1, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		// streak at limit: slot 1 goes first
		send_req(REQ_DONE, 1'b0, '0, 1'b1);
		// zero delay retry is due at once
		send_req(REQ_DONE, 1'b0, '0, 1'b0);
		send_req(REQ_DONE, 1'b0, '0, 1'b1);
		send_req(REQ_DONE, 1'b0, 16'd2, 1'b0);
		send_req(REQ_TICK, 1'b0, '0, 1'b0);
		send_req(REQ_TICK, 1'b0, '0, 1'b0);
		// cancel while running voids the retry of that job
		send_req(REQ_CANCEL, 1'b1, '0, 1'b0);
		send_req(REQ_DONE, 1'b0, '0, 1'b0);
		send_req(REQ_DONE, 1'b0, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b1, '0, 1'b0);
		send_req(REQ_DONE, 1'b0, '1, 1'b0);
		send_req(REQ_TICK, 1'b0, '0, 1'b0);
		send_req(REQ_CANCEL, 1'b1, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		send_req(REQ_DONE, 1'b0, '0, 1'b1);
		settle();
	endtask

	task automatic test_zero_limit();
		write_cfg(2'd3, 4'd0);
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b1, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		send_req(REQ_DONE, 1'b0, '0, 1'b1);
		send_req(REQ_DONE, 1'b0, '0, 1'b1);
		send_req(REQ_DONE, 1'b0, '0, 1'b1);
		settle();
	endtask

	task automatic test_random_phases();
		logic [1:0]             masks  [6];
		logic [STREAK_BITS-1:0] limits [6];
		masks  = '{2'd3, 2'd3, 2'd1, 2'd2, 2'd3, 2'd3};
		limits = '{4'd4, 4'd15, 4'd2, 4'd1, 4'd0, 4'($urandom_range(15, 1))};
		for (int p = 0; p < 6; p++) begin
			write_cfg(masks[p], limits[p]);
			// no gaps on either side for one whole phase
			quiet = (p == 1);
			repeat (PHASE_ITEMS) send_random();
			settle();
			quiet = 1'b0;
		end
	endtask

	task automatic test_generation_wrap();
		write_cfg(2'd3, 4'($urandom_range(15, 1)));
		for (int i = 0; i < WRAP_ITEMS; i++) begin
			case (i % 8)
				6:       send_req(REQ_REQUEST, 1'b0, timer_t'($urandom),
						1'($urandom_range(1)));
				7:       send_req(REQ_DONE, 1'b0, timer_t'($urandom_range(3)),
						1'($urandom_range(1)));
				default: send_req(REQ_CANCEL, 1'b0, timer_t'($urandom),
						1'($urandom_range(1)));
			endcase
		end
		settle();
	endtask

	task automatic test_stop();
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		send_req(REQ_DONE, 1'b0, 16'd1, 1'b0);
		send_req(REQ_REQUEST, 1'b1, '0, 1'b0);
		send_req(REQ_STOP, 1'b0, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b0, '0, 1'b0);
		send_req(REQ_REQUEST, 1'b1, '0, 1'b0);
		send_req(REQ_CANCEL, 1'b0, '0, 1'b0);
		send_req(REQ_TICK, 1'b0, '0, 1'b0);
		send_req(REQ_DONE, 1'b1, '0, 1'b0);
		send_req(REQ_DONE, 1'b1, '0, 1'b0);
		send_req(REQ_UNUSED_LO, 1'b1, '1, 1'b1);
		send_req(REQ_STOP, 1'b1, '1, 1'b1);
		settle();
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.accepted         = rsp_ch.accepted;
			got.grant_valid      = rsp_ch.grant_valid;
			got.grant_slot       = rsp_ch.grant_slot;
			got.grant_generation = rsp_ch.grant_generation;
			got.halted           = rsp_ch.halted;
			if (outcome_q.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOW_LIMIT)
					$display("unexpected result: acc=%0b gv=%0b gs=%0b gen=%0d halt=%0b",
						got.accepted, got.grant_valid, got.grant_slot,
						got.grant_generation, got.halted);
			end else begin
				want = outcome_q.pop_front();
				if (got.accepted !== want.accepted || got.grant_valid !== want.grant_valid ||
						got.grant_slot !== want.grant_slot ||
						got.grant_generation !== want.grant_generation ||
						got.halted !== want.halted) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT) begin
						$display("mismatch: exp acc=%0b gv=%0b gs=%0b gen=%0d halt=%0b",
							want.accepted, want.grant_valid, want.grant_slot,
							want.grant_generation, want.halted);
						$display("          got acc=%0b gv=%0b gs=%0b gen=%0d halt=%0b",
							got.accepted, got.grant_valid, got.grant_slot,
							got.grant_generation, got.halted);
					end
				end
			end
		end
	end

	// Result back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= quiet || ($urandom_range(99) >= 36);
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_BOUND_MASK;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_REQUEST;
		req_ch.slot     = 1'b0;
		req_ch.retry_ms = '0;
		req_ch.no_retry = 1'b0;
		quiet           = 1'b0;

		bound_mask   = '0;
		streak_limit = STREAK_RESET;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_pending[s] = 1'b0;
			slot_gen[s]     = '0;
			retry_on[s]     = 1'b0;
			retry_count[s]  = '0;
			retry_tag[s]    = '0;
		end
		hi_streak    = '0;
		job_running  = 1'b0;
		running_slot = 1'b0;
		running_gen  = '0;
		stopped      = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_unbound_and_unused();
		test_retry_and_cancel();
		test_zero_limit();
		test_random_phases();
		test_generation_wrap();
		test_stop();

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
